// ----- rtl/sfd_pkg.sv -----
// ============================================================================
// sfd_pkg
// Shared types, codes and reset values of the stuffed frame decoder/checker.
// ============================================================================
package sfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 4096;
    localparam int LEN_W_DEF       = $clog2(MAX_PAYLOAD_DEF + 1);

    typedef logic [7:0] byte_t;

    // configuration register indexes
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t CFG_FLAG_BYTE           = 3'd0;
    localparam cfg_index_t CFG_ESCAPE_BYTE         = 3'd1;
    localparam cfg_index_t CFG_ESCAPED_FLAG_CODE   = 3'd2;
    localparam cfg_index_t CFG_ESCAPED_ESCAPE_CODE = 3'd3;
    localparam cfg_index_t CFG_DATA_CHECK_SEED     = 3'd4;

    // configuration reset values
    localparam byte_t FLAG_BYTE_RST           = 8'h7E;
    localparam byte_t ESCAPE_BYTE_RST         = 8'h7D;
    localparam byte_t ESCAPED_FLAG_CODE_RST   = 8'h5E;
    localparam byte_t ESCAPED_ESCAPE_CODE_RST = 8'h5D;
    localparam byte_t DATA_CHECK_SEED_RST     = 8'hFF;

    typedef struct packed {
        byte_t flag_byte;
        byte_t escape_byte;
        byte_t escaped_flag_code;
        byte_t escaped_escape_code;
        byte_t data_check_seed;
    } cfg_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEADER = 3'd1,
        ST_DATA   = 3'd2,
        ST_ESCAPE = 3'd3,
        ST_SHORT  = 3'd4,
        ST_LONG   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        HDR_ADDRESS = 2'd0,
        HDR_CONTROL = 2'd1,
        HDR_CHECK   = 2'd2,
        HDR_PAYLOAD = 2'd3
    } hdr_pos_t;

endpackage

// ----- rtl/sfd_in_if.sv -----
// ============================================================================
// sfd_in_if
// Line byte channel: valid/ready handshake with one raw byte per beat.
// ============================================================================
interface sfd_in_if;
    logic           valid;
    logic           ready;
    sfd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/sfd_out_if.sv -----
// ============================================================================
// sfd_out_if
// Result channel: payload byte or end-of-frame status per beat.
// ============================================================================
interface sfd_out_if #(
    parameter int LEN_W = sfd_pkg::LEN_W_DEF
);
    logic             valid;
    logic             ready;
    logic             result_kind;
    sfd_pkg::byte_t   payload_byte;
    logic [2:0]       frame_status;
    logic [LEN_W-1:0] payload_length;
    logic             ack_sequence;

    modport source (output valid, output result_kind, output payload_byte,
                    output frame_status, output payload_length,
                    output ack_sequence, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input frame_status, input payload_length,
                    input ack_sequence, output ready);
endinterface

// ----- rtl/sfd_cfg_regs.sv -----
// ============================================================================
// sfd_cfg_regs
// Configuration register bank: five byte-wide registers, write only.
// ============================================================================
module sfd_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  sfd_pkg::cfg_index_t cfg_index,
    input  sfd_pkg::byte_t      cfg_data,
    output sfd_pkg::cfg_t       cfg
);

    sfd_pkg::cfg_t cfg_reg;
    sfd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                sfd_pkg::CFG_FLAG_BYTE:           cfg_next.flag_byte           = cfg_data;
                sfd_pkg::CFG_ESCAPE_BYTE:         cfg_next.escape_byte         = cfg_data;
                sfd_pkg::CFG_ESCAPED_FLAG_CODE:   cfg_next.escaped_flag_code   = cfg_data;
                sfd_pkg::CFG_ESCAPED_ESCAPE_CODE: cfg_next.escaped_escape_code = cfg_data;
                sfd_pkg::CFG_DATA_CHECK_SEED:     cfg_next.data_check_seed     = cfg_data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte           <= sfd_pkg::FLAG_BYTE_RST;
            cfg_reg.escape_byte         <= sfd_pkg::ESCAPE_BYTE_RST;
            cfg_reg.escaped_flag_code   <= sfd_pkg::ESCAPED_FLAG_CODE_RST;
            cfg_reg.escaped_escape_code <= sfd_pkg::ESCAPED_ESCAPE_CODE_RST;
            cfg_reg.data_check_seed     <= sfd_pkg::DATA_CHECK_SEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/sfd_deframer.sv -----
// ============================================================================
// sfd_deframer
// Per-byte frame state: flag hunt, unstuffing, header capture, one-byte
// payload delay, XOR checks and end-of-frame status.
// ============================================================================
module sfd_deframer #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF,
    parameter int LEN_W       = sfd_pkg::LEN_W_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sfd_pkg::cfg_t     cfg,
    input  logic              step,
    input  sfd_pkg::byte_t    rx_byte,
    output logic              res_valid,
    output sfd_pkg::kind_t    res_kind,
    output sfd_pkg::byte_t    res_byte,
    output sfd_pkg::status_t  res_status,
    output logic [LEN_W-1:0]  res_length,
    output logic              res_seq
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    logic               in_frame_reg, in_frame_next;
    logic               esc_pend_reg, esc_pend_next;
    sfd_pkg::hdr_pos_t  hdr_pos_reg, hdr_pos_next;
    sfd_pkg::byte_t     addr_reg, addr_next;
    sfd_pkg::byte_t     ctrl_reg, ctrl_next;
    sfd_pkg::byte_t     hchk_reg, hchk_next;
    sfd_pkg::byte_t     held_reg, held_next;
    logic               held_valid_reg, held_valid_next;
    sfd_pkg::byte_t     xor_reg, xor_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic               esc_err_reg, esc_err_next;
    logic               len_err_reg, len_err_next;
    logic               seq_reg, seq_next;

    logic               close_esc_err;
    sfd_pkg::status_t   close_status;
    sfd_pkg::byte_t     dec;
    logic               take;

    // status at the closing flag, in priority order
    always_comb
    begin
        close_esc_err = esc_err_reg | esc_pend_reg;
        if (close_esc_err)
            close_status = sfd_pkg::ST_ESCAPE;
        else if (!held_valid_reg)
            close_status = sfd_pkg::ST_SHORT;
        else if (len_err_reg)
            close_status = sfd_pkg::ST_LONG;
        else if ((addr_reg ^ ctrl_reg) != hchk_reg)
            close_status = sfd_pkg::ST_HEADER;
        else if (xor_reg != held_reg)
            close_status = sfd_pkg::ST_DATA;
        else
            close_status = sfd_pkg::ST_OK;
    end

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        esc_pend_next   = esc_pend_reg;
        hdr_pos_next    = hdr_pos_reg;
        addr_next       = addr_reg;
        ctrl_next       = ctrl_reg;
        hchk_next       = hchk_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        xor_next        = xor_reg;
        count_next      = count_reg;
        esc_err_next    = esc_err_reg;
        len_err_next    = len_err_reg;
        seq_next        = seq_reg;

        res_valid  = 1'b0;
        res_kind   = sfd_pkg::KIND_PAYLOAD;
        res_byte   = '0;
        res_status = sfd_pkg::ST_OK;
        res_length = '0;
        res_seq    = 1'b0;

        dec  = rx_byte;
        take = 1'b0;

        if (step)
        begin
            if (!in_frame_reg)
            begin
                // hunting: only an opening flag matters
                if (rx_byte == cfg.flag_byte)
                begin
                    in_frame_next   = 1'b1;
                    esc_pend_next   = 1'b0;
                    hdr_pos_next    = sfd_pkg::HDR_ADDRESS;
                    addr_next       = '0;
                    ctrl_next       = '0;
                    hchk_next       = '0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    xor_next        = cfg.data_check_seed;
                    count_next      = '0;
                    esc_err_next    = 1'b0;
                    len_err_next    = 1'b0;
                end
            end
            else if (rx_byte == cfg.flag_byte)
            begin
                // closing flag, even right after an escape byte
                res_valid     = 1'b1;
                res_kind      = sfd_pkg::KIND_STATUS;
                res_status    = close_status;
                res_length    = count_reg;
                res_seq       = seq_reg;
                esc_err_next  = close_esc_err;
                in_frame_next = 1'b0;
                esc_pend_next = 1'b0;
                if (close_status == sfd_pkg::ST_OK)
                    seq_next = ~seq_reg;
            end
            else if (esc_pend_reg)
            begin
                esc_pend_next = 1'b0;
                take          = 1'b1;
                if (rx_byte == cfg.escaped_flag_code)
                    dec = cfg.flag_byte;
                else if (rx_byte == cfg.escaped_escape_code)
                    dec = cfg.escape_byte;
                else
                    esc_err_next = 1'b1;
            end
            else if (rx_byte == cfg.escape_byte)
            begin
                esc_pend_next = 1'b1;
            end
            else
            begin
                take = 1'b1;
            end

            if (take)
            begin
                case (hdr_pos_reg)
                    sfd_pkg::HDR_ADDRESS:
                    begin
                        addr_next    = dec;
                        hdr_pos_next = sfd_pkg::HDR_CONTROL;
                    end
                    sfd_pkg::HDR_CONTROL:
                    begin
                        ctrl_next    = dec;
                        hdr_pos_next = sfd_pkg::HDR_CHECK;
                    end
                    sfd_pkg::HDR_CHECK:
                    begin
                        hchk_next    = dec;
                        hdr_pos_next = sfd_pkg::HDR_PAYLOAD;
                    end
                    sfd_pkg::HDR_PAYLOAD:
                    begin
                        // previous held byte is payload now that another byte came
                        if (held_valid_reg)
                        begin
                            if (count_reg < MAX_LEN)
                            begin
                                xor_next   = xor_reg ^ held_reg;
                                count_next = count_reg + LEN_W'(1);
                                res_valid  = 1'b1;
                                res_byte   = held_reg;
                            end
                            else
                            begin
                                len_err_next = 1'b1;
                            end
                        end
                        held_next       = dec;
                        held_valid_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            esc_pend_reg   <= 1'b0;
            hdr_pos_reg    <= sfd_pkg::HDR_ADDRESS;
            addr_reg       <= '0;
            ctrl_reg       <= '0;
            hchk_reg       <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            xor_reg        <= sfd_pkg::DATA_CHECK_SEED_RST;
            count_reg      <= '0;
            esc_err_reg    <= 1'b0;
            len_err_reg    <= 1'b0;
            seq_reg        <= 1'b0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            esc_pend_reg   <= esc_pend_next;
            hdr_pos_reg    <= hdr_pos_next;
            addr_reg       <= addr_next;
            ctrl_reg       <= ctrl_next;
            hchk_reg       <= hchk_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            xor_reg        <= xor_next;
            count_reg      <= count_next;
            esc_err_reg    <= esc_err_next;
            len_err_reg    <= len_err_next;
            seq_reg        <= seq_next;
        end
    end

    // payload count saturates at the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_LEN)
        else $error("payload count beyond limit");

    // a status beat always ends the frame
    a_close_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_kind == sfd_pkg::KIND_STATUS) |=> !in_frame_reg)
        else $error("frame still open after status");

    // a payload beat only comes from a held byte past the header
    a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_kind == sfd_pkg::KIND_PAYLOAD) |->
            (in_frame_reg && held_valid_reg && hdr_pos_reg == sfd_pkg::HDR_PAYLOAD))
        else $error("payload beat outside payload phase");

endmodule

// ----- rtl/stuffed_frame_decoder_checker.sv -----
// ============================================================================
// stuffed_frame_decoder_checker
// Receive deframer for byte-stuffed frames with XOR header and data checks.
// ============================================================================
// usage
//   rx   : raw line bytes, one per beat (valid/ready)
//   res  : one beat per payload byte, and one status beat per closing flag
//          (result_kind selects which; unused fields read zero)
//   cfg  : cfg_write/cfg_index/cfg_data, write only, change only while idle
// path
//   a byte is held in the input register, then the frame state and the
//   result register update together when the byte advances
// throughput
//   one line byte per cycle while res takes its beats
// payload bytes come out one line byte late: the last decoded byte before
//   the closing flag is the data check and is never passed on
// reset: config takes its defaults (flag 0x7e, escape 0x7d, codes 0x5e and
//   0x5d, seed 0xff), the block hunts for a flag, sequence bit is zero
// stall: the result register holds its beat, one more byte waits in the
//   input register, then rx.ready drops until res takes a beat
// ============================================================================
module stuffed_frame_decoder_checker #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    sfd_in_if.sink              rx,
    sfd_out_if.source           res,
    input  logic                cfg_write,
    input  sfd_pkg::cfg_index_t cfg_index,
    input  sfd_pkg::byte_t      cfg_data
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    sfd_pkg::cfg_t cfg;

    // input register
    logic              in_valid_reg, in_valid_next;
    sfd_pkg::byte_t    in_byte_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    sfd_pkg::kind_t    kind_reg;
    sfd_pkg::byte_t    byte_reg;
    sfd_pkg::status_t  status_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              seq_reg;

    // deframer result for the byte in the input register
    logic              dec_valid;
    sfd_pkg::kind_t    dec_kind;
    sfd_pkg::byte_t    dec_byte;
    sfd_pkg::status_t  dec_status;
    logic [LEN_W-1:0]  dec_length;
    logic              dec_seq;

    logic              load_out;
    logic              advance;
    logic              rx_beat;

    sfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the held byte is processed when the result register is free or draining
    assign load_out = !out_valid_reg || res.ready;
    assign advance  = in_valid_reg && load_out;
    assign rx.ready = !in_valid_reg || advance;
    assign rx_beat  = rx.valid && rx.ready;

    sfd_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W)
    ) u_deframer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .res_valid  (dec_valid),
        .res_kind   (dec_kind),
        .res_byte   (dec_byte),
        .res_status (dec_status),
        .res_length (dec_length),
        .res_seq    (dec_seq)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_beat)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = advance && dec_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (rx_beat)
            in_byte_reg <= rx.rx_byte;
        if (advance && dec_valid)
        begin
            kind_reg   <= dec_kind;
            byte_reg   <= dec_byte;
            status_reg <= dec_status;
            length_reg <= dec_length;
            seq_reg    <= dec_seq;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.result_kind    = kind_reg;
    assign res.payload_byte   = byte_reg;
    assign res.frame_status   = status_reg;
    assign res.payload_length = length_reg;
    assign res.ack_sequence   = seq_reg;

    // a waiting byte is neither lost nor overwritten while output is blocked
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !load_out) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input byte dropped during stall");

    // rx backpressure only comes from a blocked result register
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (out_valid_reg && !res.ready && in_valid_reg))
        else $error("rx stalled without output backpressure");

    // a stalled result beat is not replaced
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_valid_reg && $stable(status_reg)
            && $stable(byte_reg) && $stable(kind_reg)))
        else $error("result beat replaced while stalled");

endmodule
